// ===== sv/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/gfr_pkg.sv =====
// -----------------------------------------------------------------------------
// gfr_pkg
// Markers, frame positions, status codes and result type of the receiver.
// -----------------------------------------------------------------------------
package gfr_pkg;

	localparam logic [7:0] START_MARK = 8'hAF;
	localparam logic [7:0] END_MARK   = 8'hED;

	localparam int PAYLOAD_LEN = 8;

	// frame position: hunting, payload 1..8, checksum, end byte
	localparam logic [3:0] POS_HUNT     = 4'd0;
	localparam logic [3:0] POS_FIRST    = 4'd1;
	localparam logic [3:0] POS_LAST_PL  = 4'd8;
	localparam logic [3:0] POS_CHECKSUM = 4'd9;
	localparam logic [3:0] POS_END      = 4'd10;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_CSUM_ERR = 2'd1,
		STAT_END_ERR  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] left_x;
		logic [7:0] left_y;
		logic [7:0] right_x;
		logic [7:0] right_y;
		logic [7:0] left_trigger;
		logic [7:0] right_trigger;
		logic [7:0] buttons_a;
		logic [7:0] buttons_b;
		status_t    status;
	} frame_t;

endpackage

// ===== sv/gfr_byte_if.sv =====
// -----------------------------------------------------------------------------
// gfr_byte_if
// Valid/ready channel carrying one received serial byte per beat.
// -----------------------------------------------------------------------------
interface gfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/gfr_pad_if.sv =====
// -----------------------------------------------------------------------------
// gfr_pad_if
// Valid/ready channel carrying one decoded gamepad frame per beat.
// -----------------------------------------------------------------------------
interface gfr_pad_if;
	import gfr_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] left_x;
	logic [7:0] left_y;
	logic [7:0] right_x;
	logic [7:0] right_y;
	logic [7:0] left_trigger;
	logic [7:0] right_trigger;
	logic [7:0] buttons_a;
	logic [7:0] buttons_b;
	status_t    status;

	modport source (output valid, output left_x, output left_y, output right_x,
		output right_y, output left_trigger, output right_trigger,
		output buttons_a, output buttons_b, output status, input ready);
	modport sink (input valid, input left_x, input left_y, input right_x,
		input right_y, input left_trigger, input right_trigger,
		input buttons_a, input buttons_b, input status, output ready);
endinterface

// ===== sv/gfr_framer.sv =====
// -----------------------------------------------------------------------------
// gfr_framer
// Frame position tracking, payload capture, running sum and status check.
// -----------------------------------------------------------------------------
module gfr_framer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	output logic            emit,
	output gfr_pkg::frame_t frame
);
	import gfr_pkg::*;

	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] payload_q [PAYLOAD_LEN];
	logic [7:0] csum_q;
	logic [3:0] pos_m1;
	logic       hunting;
	logic       in_payload;
	logic [3:0] pos_nxt;
	logic [7:0] sum_nxt;

	assign hunting    = (pos_q == POS_HUNT) || (pos_q > POS_END);
	assign in_payload = !hunting && (pos_q <= POS_LAST_PL);
	assign emit       = (pos_q == POS_END);
	assign pos_m1     = pos_q - POS_FIRST;

	always_comb begin
		pos_nxt = pos_q;
		sum_nxt = sum_q;
		if (hunting) begin
			if (rx_byte == START_MARK) begin
				pos_nxt = POS_FIRST;
				sum_nxt = 8'd0;
			end else begin
				pos_nxt = POS_HUNT;
			end
		end else if (in_payload) begin
			pos_nxt = pos_q + 4'd1;
			sum_nxt = sum_q + rx_byte;
		end else if (pos_q == POS_CHECKSUM) begin
			pos_nxt = POS_END;
		end else begin
			pos_nxt = POS_HUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			sum_q <= 8'd0;
		end else if (step) begin
			pos_q <= pos_nxt;
			sum_q <= sum_nxt;
		end
	end

	// payload and checksum bytes need no reset
	always_ff @(posedge clk) begin
		if (step && in_payload) begin
			payload_q[pos_m1[2:0]] <= rx_byte;
		end
		if (step && (pos_q == POS_CHECKSUM)) begin
			csum_q <= rx_byte;
		end
	end

	always_comb begin
		frame.left_x        = payload_q[0];
		frame.left_y        = payload_q[1];
		frame.right_x       = payload_q[2];
		frame.right_y       = payload_q[3];
		frame.left_trigger  = payload_q[4];
		frame.right_trigger = payload_q[5];
		frame.buttons_a     = payload_q[6];
		frame.buttons_b     = payload_q[7];
		if (rx_byte != END_MARK) begin
			frame.status = STAT_END_ERR;
		end else if (sum_q != csum_q) begin
			frame.status = STAT_CSUM_ERR;
		end else begin
			frame.status = STAT_OK;
		end
	end

endmodule

// ===== sv/gamepad_frame_receiver.sv =====
// A frame result is loaded into the result register when its end byte moves on from the input register.
// Throughput: one byte per cycle while no end byte stalls, one frame every 11 bytes at best.
// The input register and the result register part the two channels, so
// bytes keep flowing while a finished frame waits on the output, until the
// next end byte reaches the input register and stalls there.
// Reset (arst_n low, asynchronous): hunting for start, no byte or result held.
// -----------------------------------------------------------------------------
// gamepad_frame_receiver
// Start/end delimited gamepad frame receiver with additive checksum check.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module gamepad_frame_receiver (
	input  logic  clk,
	input  logic  arst_n,
	gfr_byte_if.sink rx,
	gfr_pad_if.source pad
);
	import gfr_pkg::*;

	// stage 1: accepted byte
	logic       valid_s1;
	logic [7:0] byte_s1;

	// stage 2: result register
	logic       valid_s2;
	frame_t     frame_s2;

	logic       emit;
	frame_t     frame_nxt;
	logic       advance;
	logic       load_res;

	// An end byte can only move on when the result register is free or
	// being drained this cycle; every other byte moves on at once.
	assign advance  = valid_s1 && (!emit || !valid_s2 || pad.ready);
	assign load_res = advance && emit;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	gfr_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.emit    (emit),
		.frame   (frame_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_res) begin
			valid_s2 <= 1'b1;
		end else if (pad.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			frame_s2 <= frame_nxt;
		end
	end

	assign pad.valid         = valid_s2;
	assign pad.left_x        = frame_s2.left_x;
	assign pad.left_y        = frame_s2.left_y;
	assign pad.right_x       = frame_s2.right_x;
	assign pad.right_y       = frame_s2.right_y;
	assign pad.left_trigger  = frame_s2.left_trigger;
	assign pad.right_trigger = frame_s2.right_trigger;
	assign pad.buttons_a     = frame_s2.buttons_a;
	assign pad.buttons_b     = frame_s2.buttons_b;
	assign pad.status        = frame_s2.status;

	// empty result register never throttles the input
	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !valid_s2, rx.ready)
	// a held byte that cannot move on is kept, not dropped
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(byte_s1))
	// results only carry defined status codes
	`ASSERT_IMPL(a_status_code, clk, arst_n, valid_s2,
		frame_s2.status == STAT_OK || frame_s2.status == STAT_CSUM_ERR ||
		frame_s2.status == STAT_END_ERR)

endmodule

// ===== tb/tb_top.sv =====
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gamepad_frame_receiver. Serial bytes go in on
// valid/ready with random gaps. A behavioral frame tracker follows every
// accepted beat and queues the frame it expects. Each output beat is checked
// field by field against the oldest queued frame. The output side stalls at
// random and holds off for one long stretch so that the block backs up.
// -----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gfr_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int LONG_HOLD   = 300;   // output hold-off for the fill test
	localparam int SETTLE      = 8;     // settle wait after the last expected frame

	logic clk = 1'b0;
	logic arst_n;

	gfr_byte_if rx_if ();
	gfr_pad_if  pad_if ();

	gamepad_frame_receiver uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.pad    (pad_if)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Frame tracker: mirrors the receiver's hunt/capture sequence
	// ---------------------------------------------------------------------
	logic [3:0]      frame_pos;     // 0 hunt, 1..8 payload, 9 checksum, 10 end
	logic [7:0]      csum_acc;      // running mod-256 payload sum
	logic [7:0]      pad_bytes [8];
	logic [7:0]      rx_csum;
	frame_t          pending_frames [$];
	int              counted_beats;  // beats that belong to a frame, hunting junk excluded
	int              mismatch_count;
	int              cycle_count;

	// stimulus knobs, percent
	int              src_idle_pct;
	int              sink_stall_pct;

	// long output hold-off, requested by a test, counted by the ready driver
	logic            hold_pending;
	int              hold_left;

	string pad_field [8] = '{"left_x", "left_y", "right_x", "right_y",
		"left_trigger", "right_trigger", "buttons_a", "buttons_b"};

	function automatic void track_byte(input logic [7:0] b);
		frame_t done;
		// positions past the end byte are unreachable; treat them as hunting
		if (frame_pos == POS_HUNT || frame_pos > POS_END) begin
			if (b == START_MARK) begin
				csum_acc  = '0;
				frame_pos = POS_FIRST;
				counted_beats++;
			end else begin
				frame_pos = POS_HUNT;
			end
		end else begin
			counted_beats++;
			if (frame_pos <= POS_LAST_PL) begin
				// start marker inside the frame is plain data, no resync
				pad_bytes[frame_pos - POS_FIRST] = b;
				csum_acc  = csum_acc + b;
				frame_pos = frame_pos + 4'd1;
			end else if (frame_pos == POS_CHECKSUM) begin
				rx_csum   = b;
				frame_pos = POS_END;
			end else begin
				done.left_x        = pad_bytes[0];
				done.left_y        = pad_bytes[1];
				done.right_x       = pad_bytes[2];
				done.right_y       = pad_bytes[3];
				done.left_trigger  = pad_bytes[4];
				done.right_trigger = pad_bytes[5];
				done.buttons_a     = pad_bytes[6];
				done.buttons_b     = pad_bytes[7];
				// a bad end byte wins over a bad checksum
				if (b != END_MARK)
					done.status = STAT_END_ERR;
				else if (csum_acc != rx_csum)
					done.status = STAT_CSUM_ERR;
				else
					done.status = STAT_OK;
				pending_frames.push_back(done);
				frame_pos = POS_HUNT;
			end
		end
	endfunction

	// ---------------------------------------------------------------------
	// Output side: ready driver and frame checker
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_pending) begin
			hold_left = LONG_HOLD;
			hold_pending <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pad_if.ready <= 1'b0;
		end else begin
			pad_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : check_frames
		frame_t          want;
		logic [0:7][7:0] want_pl;
		logic [0:7][7:0] seen_pl;
		if (arst_n && pad_if.valid && pad_if.ready) begin
			seen_pl = {pad_if.left_x, pad_if.left_y, pad_if.right_x, pad_if.right_y,
				pad_if.left_trigger, pad_if.right_trigger, pad_if.buttons_a,
				pad_if.buttons_b};
			if (pending_frames.size() == 0) begin
				$display("%0t ns: frame beat with none expected: payload %h status %0d",
					$time, seen_pl, pad_if.status);
				mismatch_count++;
			end else begin
				want    = pending_frames.pop_front();
				want_pl = want[65:2];
				for (int k = 0; k < PAYLOAD_LEN; k++) begin
					if (seen_pl[k] !== want_pl[k]) begin
						$display("%0t ns: %s expected %02h actual %02h", $time,
							pad_field[k], want_pl[k], seen_pl[k]);
						mismatch_count++;
					end
				end
				if (pad_if.status !== want.status) begin
					$display("%0t ns: status expected %0d actual %0d", $time,
						want.status, pad_if.status);
					mismatch_count++;
				end
			end
		end
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d frames still expected", $time,
				pending_frames.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------------

	// Called at a falling edge, returns at a falling edge. Valid stays high
	// between back-to-back beats; idle cycles put junk on the data lines.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid   <= 1'b0;
			rx_if.rx_byte <= 8'($urandom);
			@(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		track_byte(b);
		@(negedge clk);
	endtask

	// start, eight payload bytes, checksum (optionally corrupted), end byte
	task automatic send_frame(input logic [0:7][7:0] pl, input logic [7:0] csum_flip,
		input logic [7:0] end_b);
		logic [7:0] s;
		s = '0;
		send_byte(START_MARK);
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			send_byte(pl[i]);
			s = s + pl[i];
		end
		send_byte(s ^ csum_flip);
		send_byte(end_b);
	endtask

	// Sender stops, waits for every queued frame, then lets the pipe settle.
	task automatic wait_frames_done();
		rx_if.valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Mostly well-formed frames with random content, some corrupted,
	// some cut short (the next bytes then finish that frame), line noise
	// in between.
	task automatic send_random_frame();
		logic [0:7][7:0] pl;
		logic [7:0]      flip;
		logic [7:0]      end_b;
		logic [7:0]      b;
		int              kind;
		repeat ($urandom_range(2)) begin
			b = 8'($urandom);
			if (b == START_MARK)
				b = ~b;
			send_byte(b);
		end
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			case ($urandom_range(11))
				0:       pl[i] = 8'h00;
				1:       pl[i] = 8'hFF;
				2:       pl[i] = START_MARK;
				3:       pl[i] = END_MARK;
				default: pl[i] = 8'($urandom);
			endcase
		end
		kind  = $urandom_range(15);
		flip  = '0;
		end_b = END_MARK;
		if (kind == 15) begin
			send_byte(START_MARK);
			repeat ($urandom_range(1, 9)) send_byte(8'($urandom));
		end else begin
			if (kind == 10 || kind == 12)
				flip = 8'($urandom_range(1, 255));
			if (kind == 11 || kind == 12) begin
				end_b = 8'($urandom);
				if (end_b == END_MARK)
					end_b = ~end_b;
			end
			send_frame(pl, flip, end_b);
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Junk while hunting (both byte extremes), then a good frame whose
	// payload carries the start and end markers and both extremes.
	task automatic test_hunt_then_good_frame();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame({8'h00, 8'hFF, START_MARK, END_MARK, 8'h01, 8'h80, 8'h55, 8'hAA},
			8'h00, END_MARK);
	endtask

	// All-ones payload (sum wraps), bad checksum and a start marker in the
	// end slot: the end-marker error must be the status reported.
	task automatic test_end_error_beats_checksum();
		send_frame({8{8'hFF}}, 8'h01, START_MARK);
	endtask

	task automatic test_random_frames(input int src_pct, input int snk_pct, input int beats);
		int first;
		src_idle_pct   = src_pct;
		sink_stall_pct = snk_pct;
		first          = counted_beats;
		while (counted_beats - first < beats)
			send_random_frame();
		wait_frames_done();
	endtask

	// Output held off for a long stretch while bytes keep coming at full
	// rate: the result register fills and the input must stall.
	task automatic test_backpressure_fill();
		logic [0:7][7:0] pl;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_pending  <= 1'b1;
		repeat (6) begin
			pl = {8{8'h00}};
			for (int i = 0; i < PAYLOAD_LEN; i++)
				pl[i] = 8'($urandom);
			send_frame(pl, 8'h00, END_MARK);
		end
		wait_frames_done();
	endtask

	initial begin
		arst_n         = 1'b0;
		rx_if.valid    = 1'b0;
		rx_if.rx_byte  = '0;
		pad_if.ready   = 1'b0;
		hold_pending   = 1'b0;
		hold_left      = 0;
		frame_pos      = POS_HUNT;
		csum_acc       = '0;
		rx_csum        = '0;
		counted_beats  = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		foreach (pad_bytes[i])
			pad_bytes[i] = '0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_hunt_then_good_frame();
		test_end_error_beats_checksum();
		wait_frames_done();

		test_random_frames(0, 0, 115);
		test_random_frames(60, 0, 115);
		test_backpressure_fill();
		test_random_frames(0, 60, 115);
		test_random_frames(38, 38, 115);

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/gfr_pkg.sv
sv/gfr_byte_if.sv
sv/gfr_pad_if.sv
sv/gfr_framer.sv
sv/gamepad_frame_receiver.sv
tb/tb_top.sv
